### sv/dlli_pkg.sv
// Shared widths, codes and types for the delay/loss link impairer.
`timescale 1ns / 1ps
package dlli_pkg;

    localparam int HOLD_DEPTH_DEF = 64;
    localparam int MAX_RESULTS    = 64;

    localparam int ID_W    = 32;
    localparam int STAMP_W = 32;
    localparam int DRAW_W  = 31;
    localparam int DELAY_W = 16;
    localparam int JIT_W   = 16;
    localparam int LOSS_W  = 7;
    localparam int LOSS_DIV = 100;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_JITTER = 2'd1;
    localparam logic [1:0] REG_LOSS   = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic V_ACCEPT = 1'b0;
    localparam logic V_DROP   = 1'b1;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [DRAW_W-1:0]  draw_t;
    typedef logic [APB_DW-1:0]  apb_data_t;
    typedef logic [APB_AW-1:0]  apb_addr_t;

endpackage

### sv/dlli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dlli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/dlli_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module dlli_rem #(
    parameter int DIV_W = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dlli_pkg::draw_t      dividend,
    input  logic [DIV_W-1:0]     divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     rem
);
    import dlli_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);

    logic [DRAW_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DRAW_W-1]};
        diff     = trial - {1'b0, div_reg};
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DRAW_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

### sv/delay_loss_link_impairer_core.sv
// Top level of the delay, jitter and loss link impairer.
//
// Input words (in_valid/in_ready) carry op, pkt_id, loss_draw and jitter_draw.
// op selects a packet arrival or a one millisecond tick. Output words
// (out_valid/out_ready) carry verdict_id, verdict (accept or drop) and last,
// which marks the final verdict caused by one input word.
// An arrival runs two bit-serial remainder units side by side (draw mod 100
// and draw mod jitter+1), one draw bit per cycle; the word is accepted, then
// divided, then decided. A dropped, zero-delay or overflow packet gets its
// verdict at the end, once the output register is free; others go to the
// hold RAM. A tick is accepted, then each released packet takes a wait state
// for the registered read of the hold RAM at the head pointer and a check
// state; a last wait and check find nothing more due.
// The output register lets the next input word in while a verdict waits.
// A stalled receiver holds the block in place while it has a further verdict to hand over.
// Reset clears the registers, pointers, count and clock; the hold RAM needs
// no clearing pass. Registers sit on the APB port at 0x0, 0x4 and 0x8.
`timescale 1ns / 1ps
module delay_loss_link_impairer_core #(
    parameter int HOLD_DEPTH = dlli_pkg::HOLD_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  dlli_pkg::apb_addr_t paddr,
    input  dlli_pkg::apb_data_t pwdata,
    output dlli_pkg::apb_data_t prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  dlli_pkg::id_t       pkt_id,
    input  dlli_pkg::draw_t     loss_draw,
    input  dlli_pkg::draw_t     jitter_draw,
    output logic                out_valid,
    input  logic                out_ready,
    output dlli_pkg::id_t       verdict_id,
    output logic                verdict,
    output logic                last
);
    import dlli_pkg::*;

    localparam int PTR_W  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int N_W    = $clog2(MAX_RESULTS + 1);
    localparam int MEM_W  = STAMP_W + ID_W;
    localparam int JDIV_W = JIT_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_TWAIT = 2'd2;
    localparam logic [1:0] ST_TCHK  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DELAY_W-1:0] delay_ms_reg;
    logic [JIT_W-1:0]   jitter_ms_reg;
    logic [LOSS_W-1:0]  loss_pct_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    stamp_t             current_time_reg, current_time_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic               pend_valid_reg, pend_valid_next;
    id_t                pend_id_reg, pend_id_next;
    id_t                arr_id_reg, arr_id_next;
    logic               out_valid_reg, out_valid_next;
    id_t                verdict_id_reg, verdict_id_next;
    logic               verdict_reg, verdict_next;
    logic               last_reg, last_next;

    logic               cfg_wr;
    logic               in_fire;
    logic               div_start;
    logic               loss_done, jit_done;
    logic [LOSS_W-1:0]  loss_rem;
    logic [JDIV_W-1:0]  jit_rem;
    logic [JDIV_W-1:0]  jit_div;
    logic               drop;
    logic [JIT_W-1:0]   jit_add;
    logic [JDIV_W-1:0]  delay_sum;
    logic               hold_full;
    logic               out_free;
    logic               ram_we;
    logic [MEM_W-1:0]   ram_wdata;
    logic [MEM_W-1:0]   ram_rdata;
    stamp_t             head_due;
    id_t                head_id;
    stamp_t             age;
    logic               entry_due;

    // APB register file
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ms_reg  <= '0;
            jitter_ms_reg <= '0;
            loss_pct_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DELAY:  delay_ms_reg  <= pwdata[DELAY_W-1:0];
                REG_JITTER: jitter_ms_reg <= pwdata[JIT_W-1:0];
                REG_LOSS:   loss_pct_reg  <= pwdata[LOSS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DELAY:  prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_ms_reg};
            REG_JITTER: prdata = {{(APB_DW-JIT_W){1'b0}}, jitter_ms_reg};
            REG_LOSS:   prdata = {{(APB_DW-LOSS_W){1'b0}}, loss_pct_reg};
            default:    prdata = '0;
        endcase
    end

    // Remainder units
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign div_start = in_fire && (op == OP_ARRIVE);
    assign jit_div   = {1'b0, jitter_ms_reg} + JDIV_W'(1);

    dlli_rem #(
        .DIV_W (LOSS_W)
    ) u_loss_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (loss_draw),
        .divisor  (LOSS_W'(LOSS_DIV)),
        .done     (loss_done),
        .rem      (loss_rem)
    );

    dlli_rem #(
        .DIV_W (JDIV_W)
    ) u_jit_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (jitter_draw),
        .divisor  (jit_div),
        .done     (jit_done),
        .rem      (jit_rem)
    );

    // Hold RAM: {due, id}
    dlli_ram #(
        .WIDTH (MEM_W),
        .DEPTH (HOLD_DEPTH),
        .AW    (PTR_W)
    ) u_hold_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign head_due  = ram_rdata[MEM_W-1:ID_W];
    assign head_id   = ram_rdata[ID_W-1:0];
    assign age       = current_time_reg - head_due;
    assign entry_due = (count_reg != '0) && (n_reg < N_W'(MAX_RESULTS)) && !age[STAMP_W-1];

    assign drop      = (loss_pct_reg != '0) && (loss_rem < loss_pct_reg);
    assign jit_add   = (jitter_ms_reg != '0) ? jit_rem[JIT_W-1:0] : '0;
    assign delay_sum = {1'b0, delay_ms_reg} + {1'b0, jit_add};
    assign hold_full = (count_reg == CNT_W'(HOLD_DEPTH));
    assign out_free  = !out_valid_reg || out_ready;
    assign ram_wdata = {current_time_reg + STAMP_W'(delay_sum), arr_id_reg};

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        current_time_next = current_time_reg;
        n_next            = n_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        arr_id_next       = arr_id_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        verdict_id_next   = verdict_id_reg;
        verdict_next      = verdict_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_TICK)
                    begin
                        current_time_next = current_time_reg + STAMP_W'(1);
                        n_next            = '0;
                        pend_valid_next   = 1'b0;
                        state_next        = ST_TWAIT;
                    end
                    else
                    begin
                        arr_id_next = pkt_id;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (loss_done && jit_done)
                begin
                    if (drop || (delay_sum == '0) || hold_full)
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            verdict_id_next = arr_id_reg;
                            verdict_next    = drop ? V_DROP : V_ACCEPT;
                            last_next       = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        tail_next  = (tail_reg == PTR_W'(HOLD_DEPTH - 1)) ?
                                     '0 : tail_reg + PTR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TWAIT:
            begin
                state_next = ST_TCHK;
            end
            ST_TCHK:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        verdict_id_next = pend_id_reg;
                        verdict_next    = V_ACCEPT;
                        last_next       = !entry_due;
                    end
                    if (entry_due)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = head_id;
                        head_next       = (head_reg == PTR_W'(HOLD_DEPTH - 1)) ?
                                          '0 : head_reg + PTR_W'(1);
                        count_next      = count_reg - CNT_W'(1);
                        n_next          = n_reg + N_W'(1);
                        state_next      = ST_TWAIT;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            current_time_reg <= '0;
            n_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            current_time_reg <= current_time_next;
            n_reg            <= n_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        arr_id_reg     <= arr_id_next;
        verdict_id_reg <= verdict_id_next;
        verdict_reg    <= verdict_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign verdict_id = verdict_id_reg;
    assign verdict    = verdict_reg;
    assign last       = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HOLD_DEPTH))
        else $error("hold count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == V_DROP)) |-> last)
        else $error("drop verdict not marked last");

    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_TICK)) |=>
        (current_time_reg == $past(current_time_reg) + STAMP_W'(1)))
        else $error("tick did not advance the clock");

endmodule
